### src/uhc_pkg.sv
package uhc_pkg;

   localparam logic [16:0] MAX_PAYLOAD_BYTES = 17'd65507;
   localparam logic [15:0] IP_HEADER_BYTES   = 16'd20;
   localparam logic [15:0] UDP_HEADER_BYTES  = 16'd8;
   localparam logic [15:0] VERSION_IHL_WORD  = 16'h4500;
   localparam logic [7:0]  PROTO_UDP         = 8'd17;
   localparam logic [15:0] CHECKSUM_ONES     = 16'hFFFF;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_ADDRESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_PORT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_PORT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_TO_LIVE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_TYPE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_IDENT   = 3'd6;

   localparam logic [31:0] RESET_ADDRESS     = 32'h7F00_0001;
   localparam logic [15:0] RESET_SOURCE_PORT = 16'd60001;
   localparam logic [15:0] RESET_DEST_PORT   = 16'd60002;
   localparam logic [7:0]  RESET_TTL         = 8'd255;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  time_to_live;
      logic [7:0]  service_type;
      logic [15:0] packet_ident;
   } cfg_type;

   // finished payload: saturating byte count and folded payload sum
   typedef struct packed {
      logic [16:0] count;
      logic [15:0] psum;
   } fin_type;

   // end-around carry fold of up to sixteen 16-bit words
   function automatic logic [15:0] fold20(input logic [19:0] v);
      logic [16:0] a;
      a = 17'(v[15:0]) + 17'(v[19:16]);
      return a[15:0] + 16'(a[16]);
   endfunction

endpackage

### src/uhc_ifs.sv
interface uhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, payload_byte, has_byte, last_byte, input ready);
   modport sink (input valid, payload_byte, has_byte, last_byte, output ready);
endinterface

interface uhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ip_total_length;
   logic [15:0] udp_length;
   logic [15:0] ip_header_checksum;
   logic [15:0] udp_checksum;
   logic        length_error;

   modport source (output valid, ip_total_length, udp_length, ip_header_checksum,
                   udp_checksum, length_error, input ready);
   modport sink (input valid, ip_total_length, udp_length, ip_header_checksum,
                 udp_checksum, length_error, output ready);
endinterface

### src/uhc_accum.sv
module uhc_accum (
   input  logic              clock,
   input  logic              reset,
   uhc_req_if.sink           req_bus,
   output uhc_pkg::fin_type  fin,
   output logic              fin_valid,
   input  logic              fin_ready
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_has_ff;
   logic        in_last_ff;

   logic [16:0] count_ff;
   logic [15:0] sum_ff;
   logic [7:0]  held_ff;
   logic        odd_ff;

   logic              fin_valid_ff;
   uhc_pkg::fin_type  fin_ff;

   logic              fin_free;
   logic              in_go;
   logic              accept;
   logic [16:0]       count_in;
   logic [15:0]       word;
   logic              add_en;
   logic [15:0]       sum_in;
   uhc_pkg::fin_type  fin_in;

   assign fin_free = !fin_valid_ff || fin_ready;
   assign in_go    = in_valid_ff && (!in_last_ff || fin_free);
   assign req_bus.ready = !in_valid_ff || in_go;
   assign accept   = req_bus.valid && req_bus.ready;

   always_comb begin
      count_in = count_ff;
      if (in_has_ff && count_ff <= uhc_pkg::MAX_PAYLOAD_BYTES) begin
         count_in = count_ff + 17'd1;
      end
      // pair completes a word; an odd tail at end of payload pads low byte with zero
      word   = odd_ff ? {held_ff, (in_has_ff ? in_byte_ff : 8'h00)} : {in_byte_ff, 8'h00};
      add_en = (in_has_ff && odd_ff) || (in_last_ff && (in_has_ff || odd_ff));
      sum_in = add_en ? uhc_pkg::fold20(20'(sum_ff) + 20'(word)) : sum_ff;
      fin_in.count = count_in;
      fin_in.psum  = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (accept) begin
         in_byte_ff <= req_bus.payload_byte;
         in_has_ff  <= req_bus.has_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
      end else if (in_go) begin
         if (in_last_ff) begin
            count_ff <= '0;
            sum_ff   <= '0;
            held_ff  <= '0;
            odd_ff   <= 1'b0;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            if (in_has_ff) begin
               if (odd_ff) begin
                  odd_ff <= 1'b0;
               end else begin
                  held_ff <= in_byte_ff;
                  odd_ff  <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_free) begin
         fin_valid_ff <= in_go && in_last_ff;
      end
      if (fin_free && in_go && in_last_ff) begin
         fin_ff <= fin_in;
      end
   end

   assign fin       = fin_ff;
   assign fin_valid = fin_valid_ff;

endmodule

### src/uhc_csum.sv
module uhc_csum (
   input  logic              clock,
   input  logic              reset,
   input  uhc_pkg::cfg_type  cfg,
   input  uhc_pkg::fin_type  fin,
   input  logic              fin_valid,
   output logic              fin_ready,
   uhc_rsp_if.source         rsp_bus
);

   logic [15:0] ip_base_ff;
   logic [15:0] udp_base_ff;
   logic [15:0] ip_base_in;
   logic [15:0] udp_base_in;

   logic        rsp_valid_ff;
   logic [15:0] total_len_ff;
   logic [15:0] udp_len_ff;
   logic [15:0] ip_sum_ff;
   logic [15:0] udp_sum_ff;
   logic        err_ff;

   logic        err_in;
   logic [15:0] len;
   logic [15:0] udp_len_in;
   logic [15:0] total_len_in;
   logic [15:0] ip_sum_in;
   logic [15:0] udp_raw;
   logic [15:0] udp_sum_in;

   // configuration-only part of both sums, registered behind the configuration registers
   always_comb begin
      ip_base_in = uhc_pkg::fold20(
         20'(uhc_pkg::VERSION_IHL_WORD | 16'(cfg.service_type))
         + 20'(cfg.packet_ident)
         + 20'({cfg.time_to_live, uhc_pkg::PROTO_UDP})
         + 20'(cfg.source_address[31:16]) + 20'(cfg.source_address[15:0])
         + 20'(cfg.dest_address[31:16]) + 20'(cfg.dest_address[15:0]));
      udp_base_in = uhc_pkg::fold20(
         20'(cfg.source_address[31:16]) + 20'(cfg.source_address[15:0])
         + 20'(cfg.dest_address[31:16]) + 20'(cfg.dest_address[15:0])
         + 20'(uhc_pkg::PROTO_UDP)
         + 20'(cfg.source_port) + 20'(cfg.dest_port));
   end

   always_ff @(posedge clock) begin
      ip_base_ff  <= ip_base_in;
      udp_base_ff <= udp_base_in;
   end

   always_comb begin
      err_in       = fin.count > uhc_pkg::MAX_PAYLOAD_BYTES;
      len          = err_in ? uhc_pkg::MAX_PAYLOAD_BYTES[15:0] : fin.count[15:0];
      udp_len_in   = len + uhc_pkg::UDP_HEADER_BYTES;
      total_len_in = udp_len_in + uhc_pkg::IP_HEADER_BYTES;
      ip_sum_in    = ~uhc_pkg::fold20(20'(ip_base_ff) + 20'(total_len_in));
      // UDP length appears in both the pseudo-header and the UDP header
      udp_raw      = ~uhc_pkg::fold20(20'(udp_base_ff) + 20'(fin.psum)
                                      + 20'(udp_len_in) + 20'(udp_len_in));
      udp_sum_in   = (udp_raw == 16'h0000) ? uhc_pkg::CHECKSUM_ONES : udp_raw;
   end

   assign fin_ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         rsp_valid_ff <= fin_valid;
      end
      if (fin_ready && fin_valid) begin
         total_len_ff <= total_len_in;
         udp_len_ff   <= udp_len_in;
         ip_sum_ff    <= ip_sum_in;
         udp_sum_ff   <= udp_sum_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.ip_total_length    = total_len_ff;
   assign rsp_bus.udp_length         = udp_len_ff;
   assign rsp_bus.ip_header_checksum = ip_sum_ff;
   assign rsp_bus.udp_checksum       = udp_sum_ff;
   assign rsp_bus.length_error       = err_ff;

endmodule

### src/udp_ipv4_header_checksum.sv
// Channel   Direction  Carries
// req_bus   in         payload_byte, has_byte, last_byte
// rsp_bus   out        ip_total_length, udp_length, ip_header_checksum,
//                      udp_checksum, length_error
// csr_*     in         write enable, register index, 32-bit write data
//
// One beat per cycle unless a last beat is held by a stalled result; the running
// payload sum takes one end-around add per beat. A result passes from its last beat
// through the input register, the finish register and the result register.
// Synchronous active-high reset clears the payload state, the pipeline valids
// and the registers to their defaults.
// A stalled result holds only the stages behind it that carry a last beat.
module udp_ipv4_header_checksum (
   input  logic                                 clock,
   input  logic                                 reset,
   uhc_req_if.sink                              req_bus,
   uhc_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [uhc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [uhc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   uhc_pkg::cfg_type  cfg_ff;
   uhc_pkg::fin_type  fin;
   logic              fin_valid;
   logic              fin_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address <= uhc_pkg::RESET_ADDRESS;
         cfg_ff.dest_address   <= uhc_pkg::RESET_ADDRESS;
         cfg_ff.source_port    <= uhc_pkg::RESET_SOURCE_PORT;
         cfg_ff.dest_port      <= uhc_pkg::RESET_DEST_PORT;
         cfg_ff.time_to_live   <= uhc_pkg::RESET_TTL;
         cfg_ff.service_type   <= '0;
         cfg_ff.packet_ident   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            uhc_pkg::CSR_SOURCE_ADDRESS: cfg_ff.source_address <= csr_write_data;
            uhc_pkg::CSR_DEST_ADDRESS:   cfg_ff.dest_address   <= csr_write_data;
            uhc_pkg::CSR_SOURCE_PORT:    cfg_ff.source_port    <= csr_write_data[15:0];
            uhc_pkg::CSR_DEST_PORT:      cfg_ff.dest_port      <= csr_write_data[15:0];
            uhc_pkg::CSR_TIME_TO_LIVE:   cfg_ff.time_to_live   <= csr_write_data[7:0];
            uhc_pkg::CSR_SERVICE_TYPE:   cfg_ff.service_type   <= csr_write_data[7:0];
            uhc_pkg::CSR_PACKET_IDENT:   cfg_ff.packet_ident   <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   uhc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .fin       (fin),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready)
   );

   uhc_csum u_csum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fin       (fin),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTH
   a_len_relation: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.ip_total_length
                        == rsp_bus.udp_length + uhc_pkg::IP_HEADER_BYTES)
      else $error("total length and UDP length disagree");

   a_err_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.length_error) |->
         rsp_bus.udp_length == uhc_pkg::MAX_PAYLOAD_BYTES[15:0] + uhc_pkg::UDP_HEADER_BYTES)
      else $error("length error without saturated length");

   a_udp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.udp_checksum != 16'h0000)
      else $error("UDP checksum of zero sent");

   a_fin_held: assert property (@(posedge clock) disable iff (reset)
      (fin_valid && !fin_ready) |=> fin_valid && $stable(fin))
      else $error("finished payload lost under stall");
`endif

endmodule
